### rtl/sie_pkg.sv
// Shared types, constants and decode helpers for the SM83 instruction executor.
// No dependencies.
package sie_pkg;

    localparam logic [15:0] PC_RESET  = 16'h0100;
    localparam logic [15:0] SP_RESET  = 16'hFFFE;
    localparam logic [15:0] BC_RESET  = 16'h0013;
    localparam logic [15:0] DE_RESET  = 16'h00D8;
    localparam logic [15:0] HL_RESET  = 16'h014D;
    localparam logic [7:0]  A_RESET   = 8'h01;
    localparam logic [3:0]  F_RESET   = 4'b1011;
    localparam int          IN_DEPTH  = 2;
    localparam int          OUT_DEPTH = 2;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBC = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    localparam logic [2:0] REG_MEM = 3'd6;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  imm_low;
        logic [7:0]  imm_high;
        logic [15:0] read_data;
        logic [1:0]  len;
        logic        bad;
    } sie_item_t;

    typedef struct packed {
        logic [15:0] read_addr;
        logic        write_enable;
        logic [15:0] write_addr;
        logic [15:0] write_data;
        logic        write_word;
        logic [15:0] next_pc;
        logic [7:0]  acc_out;
        logic [3:0]  flags_out;
        logic        irq_enable;
        logic        halted;
        logic        stopped;
        logic        illegal;
    } sie_result_t;

    function automatic logic [1:0] op_length(input logic [7:0] op);
        logic [1:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [1:0] len;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        len = 2'd1;
        if (x == 2'd0) begin
            if (z == 3'd0)
                len = (y == 3'd0) ? 2'd1 : ((y == 3'd1) ? 2'd3 : 2'd2);
            else if (z == 3'd1 && !y[0])
                len = 2'd3;
            else if (z == 3'd6)
                len = 2'd2;
        end else if (x == 2'd3) begin
            case (z)
                3'd0: len = y[2] ? 2'd2 : 2'd1;
                3'd2: len = (!y[2] || y == 3'd5 || y == 3'd7) ? 2'd3 : 2'd1;
                3'd3: len = (y == 3'd0) ? 2'd3 : ((y == 3'd1) ? 2'd2 : 2'd1);
                3'd4: len = !y[2] ? 2'd3 : 2'd1;
                3'd5: len = (y == 3'd1) ? 2'd3 : 2'd1;
                3'd6: len = 2'd2;
                default: len = 2'd1;
            endcase
        end
        return len;
    endfunction

    function automatic logic op_unused(input logic [7:0] op);
        return op inside {8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB,
                          8'hEC, 8'hED, 8'hF4, 8'hFC, 8'hFD};
    endfunction

endpackage

### rtl/sie_fifo.sv
// Small synchronous queue used between the ports and the front and back parts.
// Depends on nothing.
module sie_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end
endmodule

### rtl/sie_front.sv
// Front part: takes items, works out instruction length and unused opcodes,
// and queues the classified items. Depends on sie_pkg and sie_fifo.
module sie_front #(
    parameter int DEPTH = sie_pkg::IN_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        opcode,
    input  logic [7:0]        imm_low,
    input  logic [7:0]        imm_high,
    input  logic [15:0]       read_data,
    input  logic              take,
    output logic              avail,
    output sie_pkg::sie_item_t item
);
    import sie_pkg::*;

    sie_item_t cls;
    logic      q_empty;

    always_comb
    begin
        cls.opcode    = opcode;
        cls.imm_low   = imm_low;
        cls.imm_high  = imm_high;
        cls.read_data = read_data;
        cls.len       = op_length(opcode);
        cls.bad       = op_unused(opcode);
    end

    sie_fifo #(.W($bits(sie_item_t)), .DEPTH(DEPTH)) u_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cls),
        .full  (full),
        .pop   (take),
        .dout  (item),
        .empty (q_empty)
    );

    assign avail = !q_empty;
endmodule

### rtl/sie_back.sv
// Back part: register file, flags and status bits; executes one item per cycle while fire is high.
// Depends on sie_pkg.
module sie_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sie_pkg::sie_item_t  item,
    output sie_pkg::sie_result_t res
);
    import sie_pkg::*;

    logic [15:0] pc_reg, sp_reg, bc_reg, de_reg, hl_reg;
    logic [7:0]  a_reg;
    logic [3:0]  f_reg;
    logic        ime_reg, halt_reg, stop_reg;

    logic [15:0] pc_next, sp_next, bc_next, de_next, hl_next;
    logic [7:0]  a_next;
    logic [3:0]  f_next;
    logic        ime_next, halt_next, stop_next;

    function automatic logic [11:0] alu_op(input logic [2:0] op, input logic [7:0] a,
                                           input logic [7:0] v, input logic [3:0] f);
        logic       cin;
        logic [8:0] r;
        logic [4:0] hs;
        logic [7:0] rs;
        logic [3:0] fo;
        cin = 1'b0;
        r   = '0;
        hs  = '0;
        rs  = a;
        fo  = f;
        case (op)
            ALU_ADD, ALU_ADC:
            begin
                cin = (op == ALU_ADC) ? f[0] : 1'b0;
                r   = {1'b0, a} + {1'b0, v} + 9'(cin);
                hs  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + 5'(cin);
                rs  = r[7:0];
                fo  = {rs == 8'd0, 1'b0, hs[4], r[8]};
            end
            ALU_SUB, ALU_SBC, ALU_CP:
            begin
                cin = (op == ALU_SBC) ? f[0] : 1'b0;
                r   = {1'b0, a} - {1'b0, v} - 9'(cin);
                hs  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - 5'(cin);
                rs  = (op == ALU_CP) ? a : r[7:0];
                fo  = {r[7:0] == 8'd0, 1'b1, hs[4], r[8]};
            end
            ALU_AND:
            begin
                rs = a & v;
                fo = {rs == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            ALU_XOR:
            begin
                rs = a ^ v;
                fo = {rs == 8'd0, 3'b000};
            end
            default:
            begin
                rs = a | v;
                fo = {rs == 8'd0, 3'b000};
            end
        endcase
        return {rs, fo};
    endfunction

    function automatic logic [8:0] shift_op(input logic [2:0] kind, input logic [7:0] v,
                                            input logic cin);
        logic [7:0] r;
        logic       c;
        case (kind)
            SH_RLC:  begin r = {v[6:0], v[7]};  c = v[7]; end
            SH_RRC:  begin r = {v[0], v[7:1]};  c = v[0]; end
            SH_RL:   begin r = {v[6:0], cin};   c = v[7]; end
            SH_RR:   begin r = {cin, v[7:1]};   c = v[0]; end
            SH_SLA:  begin r = {v[6:0], 1'b0};  c = v[7]; end
            SH_SRA:  begin r = {v[7], v[7:1]};  c = v[0]; end
            SH_SWAP: begin r = {v[3:0], v[7:4]}; c = 1'b0; end
            default: begin r = {1'b0, v[7:1]};  c = v[0]; end
        endcase
        return {c, r};
    endfunction

    function automatic logic cond_met(input logic [1:0] cc, input logic [3:0] f);
        logic m;
        case (cc)
            2'd0: m = !f[3];
            2'd1: m = f[3];
            2'd2: m = !f[0];
            default: m = f[0];
        endcase
        return m;
    endfunction

    always_comb
    begin
        logic [1:0]  x, p;
        logic [2:0]  y, z, idx, bsel;
        logic        q, w8_en;
        logic [2:0]  w8_idx;
        logic [7:0]  w8_val, lo, v8, mem8, bitmask, src;
        logic [15:0] nn, seq, nxt, ea, sext, s16;
        logic [16:0] r17;
        logic [12:0] h13;
        logic [4:0]  h5;
        logic [8:0]  c9, sh;
        logic [11:0] al;
        logic        dc;

        x    = item.opcode[7:6];
        y    = item.opcode[5:3];
        z    = item.opcode[2:0];
        p    = y[2:1];
        q    = y[0];
        lo   = item.imm_low;
        nn   = {item.imm_high, item.imm_low};
        mem8 = item.read_data[7:0];
        sext = {{8{lo[7]}}, lo};
        seq  = pc_reg + 16'(item.len);
        nxt  = seq;

        sp_next   = sp_reg;
        bc_next   = bc_reg;
        de_next   = de_reg;
        hl_next   = hl_reg;
        a_next    = a_reg;
        f_next    = f_reg;
        ime_next  = ime_reg;
        halt_next = halt_reg;
        stop_next = stop_reg;

        res = '0;
        w8_en  = 1'b0;
        w8_idx = '0;
        w8_val = '0;
        idx = '0; bsel = '0; v8 = '0; bitmask = '0; src = '0;
        ea = '0; s16 = '0; r17 = '0; h13 = '0; h5 = '0; c9 = '0; sh = '0; al = '0;
        dc = 1'b0;

        // operand source: register or (HL) for the selected index
        idx = (x == 2'd3) ? lo[2:0] : ((x == 2'd0) ? y : z);
        case (idx)
            3'd0: src = bc_reg[15:8];
            3'd1: src = bc_reg[7:0];
            3'd2: src = de_reg[15:8];
            3'd3: src = de_reg[7:0];
            3'd4: src = hl_reg[15:8];
            3'd5: src = hl_reg[7:0];
            REG_MEM: src = mem8;
            default: src = a_reg;
        endcase
        case (p)
            2'd0: s16 = bc_reg;
            2'd1: s16 = de_reg;
            2'd2: s16 = hl_reg;
            default: s16 = sp_reg;
        endcase

        case (x)
            2'd0:
            begin
                case (z)
                    3'd0:
                    begin
                        if (y == 3'd1)
                        begin
                            res.write_enable = 1'b1;
                            res.write_word   = 1'b1;
                            res.write_addr   = nn;
                            res.write_data   = sp_reg;
                        end
                        else if (y == 3'd2)
                        begin
                            if (lo == 8'd0)
                                stop_next = 1'b1;
                        end
                        else if (y == 3'd3 || (y[2] && cond_met(y[1:0], f_reg)))
                            nxt = seq + sext;
                    end
                    3'd1:
                    begin
                        if (!q)
                        begin
                            case (p)
                                2'd0: bc_next = nn;
                                2'd1: de_next = nn;
                                2'd2: hl_next = nn;
                                default: sp_next = nn;
                            endcase
                        end
                        else
                        begin
                            r17 = {1'b0, hl_reg} + {1'b0, s16};
                            h13 = {1'b0, hl_reg[11:0]} + {1'b0, s16[11:0]};
                            f_next  = {f_reg[3], 1'b0, h13[12], r17[16]};
                            hl_next = r17[15:0];
                        end
                    end
                    3'd2:
                    begin
                        ea = (p == 2'd0) ? bc_reg : ((p == 2'd1) ? de_reg : hl_reg);
                        if (!q)
                        begin
                            res.write_enable = 1'b1;
                            res.write_addr   = ea;
                            res.write_data   = {8'd0, a_reg};
                        end
                        else
                        begin
                            res.read_addr = ea;
                            a_next        = mem8;
                        end
                        if (p == 2'd2)
                            hl_next = hl_reg + 16'd1;
                        if (p == 2'd3)
                            hl_next = hl_reg - 16'd1;
                    end
                    3'd3:
                    begin
                        ea = q ? s16 - 16'd1 : s16 + 16'd1;
                        case (p)
                            2'd0: bc_next = ea;
                            2'd1: de_next = ea;
                            2'd2: hl_next = ea;
                            default: sp_next = ea;
                        endcase
                    end
                    3'd4:
                    begin
                        if (y == REG_MEM)
                            res.read_addr = hl_reg;
                        v8     = src + 8'd1;
                        f_next = {v8 == 8'd0, 1'b0, src[3:0] == 4'hF, f_reg[0]};
                        w8_en  = 1'b1; w8_idx = y; w8_val = v8;
                    end
                    3'd5:
                    begin
                        if (y == REG_MEM)
                            res.read_addr = hl_reg;
                        v8     = src - 8'd1;
                        f_next = {v8 == 8'd0, 1'b1, src[3:0] == 4'h0, f_reg[0]};
                        w8_en  = 1'b1; w8_idx = y; w8_val = v8;
                    end
                    3'd6:
                    begin
                        w8_en = 1'b1; w8_idx = y; w8_val = lo;
                    end
                    default:
                    begin
                        if (!y[2])
                        begin
                            sh     = shift_op(y, a_reg, f_reg[0]);
                            a_next = sh[7:0];
                            f_next = {3'b000, sh[8]};
                        end
                        else if (y == 3'd4)
                        begin
                            v8 = a_reg;
                            dc = f_reg[0];
                            if (!f_reg[2])
                            begin
                                if (dc || a_reg > 8'h99)
                                begin
                                    v8 = v8 + 8'h60;
                                    dc = 1'b1;
                                end
                                if (f_reg[1] || v8[3:0] > 4'd9)
                                    v8 = v8 + 8'h06;
                            end
                            else
                            begin
                                if (dc)
                                    v8 = v8 - 8'h60;
                                if (f_reg[1])
                                    v8 = v8 - 8'h06;
                            end
                            a_next = v8;
                            f_next = {v8 == 8'd0, f_reg[2], 1'b0, dc};
                        end
                        else if (y == 3'd5)
                        begin
                            a_next = ~a_reg;
                            f_next = f_reg | 4'b0110;
                        end
                        else if (y == 3'd6)
                            f_next = {f_reg[3], 3'b001};
                        else
                            f_next = {f_reg[3], 2'b00, !f_reg[0]};
                    end
                endcase
            end
            2'd1:
            begin
                if (y == REG_MEM && z == REG_MEM)
                    halt_next = 1'b1;
                else
                begin
                    if (z == REG_MEM)
                        res.read_addr = hl_reg;
                    w8_en = 1'b1; w8_idx = y; w8_val = src;
                end
            end
            2'd2:
            begin
                if (z == REG_MEM)
                    res.read_addr = hl_reg;
                al     = alu_op(y, a_reg, src, f_reg);
                a_next = al[11:4];
                f_next = al[3:0];
            end
            default:
            begin
                case (z)
                    3'd0:
                    begin
                        if (!y[2])
                        begin
                            if (cond_met(y[1:0], f_reg))
                            begin
                                res.read_addr = sp_reg;
                                sp_next       = sp_reg + 16'd2;
                                nxt           = item.read_data;
                            end
                        end
                        else if (y == 3'd4)
                        begin
                            res.write_enable = 1'b1;
                            res.write_addr   = {8'hFF, lo};
                            res.write_data   = {8'd0, a_reg};
                        end
                        else if (y == 3'd6)
                        begin
                            res.read_addr = {8'hFF, lo};
                            a_next        = mem8;
                        end
                        else
                        begin
                            h5 = {1'b0, sp_reg[3:0]} + {1'b0, lo[3:0]};
                            c9 = {1'b0, sp_reg[7:0]} + {1'b0, lo};
                            f_next = {2'b00, h5[4], c9[8]};
                            ea = sp_reg + sext;
                            if (y == 3'd5)
                                sp_next = ea;
                            else
                                hl_next = ea;
                        end
                    end
                    3'd1:
                    begin
                        if (!q)
                        begin
                            res.read_addr = sp_reg;
                            sp_next       = sp_reg + 16'd2;
                            case (p)
                                2'd0: bc_next = item.read_data;
                                2'd1: de_next = item.read_data;
                                2'd2: hl_next = item.read_data;
                                default:
                                begin
                                    a_next = item.read_data[15:8];
                                    f_next = item.read_data[7:4];
                                end
                            endcase
                        end
                        else if (!p[1])
                        begin
                            res.read_addr = sp_reg;
                            sp_next       = sp_reg + 16'd2;
                            nxt           = item.read_data;
                            if (p[0])
                                ime_next = 1'b1;
                        end
                        else if (p == 2'd2)
                            nxt = hl_reg;
                        else
                            sp_next = hl_reg;
                    end
                    3'd2:
                    begin
                        if (!y[2])
                        begin
                            if (cond_met(y[1:0], f_reg))
                                nxt = nn;
                        end
                        else if (y == 3'd4 || y == 3'd5)
                        begin
                            res.write_enable = 1'b1;
                            res.write_addr   = (y == 3'd4) ? {8'hFF, bc_reg[7:0]} : nn;
                            res.write_data   = {8'd0, a_reg};
                        end
                        else
                        begin
                            res.read_addr = (y == 3'd6) ? {8'hFF, bc_reg[7:0]} : nn;
                            a_next        = mem8;
                        end
                    end
                    3'd3:
                    begin
                        if (y == 3'd0)
                            nxt = nn;
                        else if (y == 3'd1)
                        begin
                            if (lo[2:0] == REG_MEM)
                                res.read_addr = hl_reg;
                            bsel    = lo[5:3];
                            bitmask = 8'd1 << bsel;
                            case (lo[7:6])
                                2'd0:
                                begin
                                    sh     = shift_op(bsel, src, f_reg[0]);
                                    f_next = {sh[7:0] == 8'd0, 2'b00, sh[8]};
                                    w8_en  = 1'b1; w8_idx = lo[2:0]; w8_val = sh[7:0];
                                end
                                2'd1:
                                    f_next = {(src & bitmask) == 8'd0, 2'b01, f_reg[0]};
                                2'd2:
                                begin
                                    w8_en = 1'b1; w8_idx = lo[2:0]; w8_val = src & ~bitmask;
                                end
                                default:
                                begin
                                    w8_en = 1'b1; w8_idx = lo[2:0]; w8_val = src | bitmask;
                                end
                            endcase
                        end
                        else if (y == 3'd6)
                            ime_next = 1'b0;
                        else if (y == 3'd7)
                            ime_next = 1'b1;
                    end
                    3'd4:
                    begin
                        if (!y[2] && cond_met(y[1:0], f_reg))
                        begin
                            sp_next          = sp_reg - 16'd2;
                            res.write_enable = 1'b1;
                            res.write_word   = 1'b1;
                            res.write_addr   = sp_reg - 16'd2;
                            res.write_data   = seq;
                            nxt              = nn;
                        end
                    end
                    3'd5:
                    begin
                        if (!q || p == 2'd0)
                        begin
                            sp_next          = sp_reg - 16'd2;
                            res.write_enable = 1'b1;
                            res.write_word   = 1'b1;
                            res.write_addr   = sp_reg - 16'd2;
                            if (q)
                            begin
                                res.write_data = seq;
                                nxt            = nn;
                            end
                            else if (p == 2'd3)
                                res.write_data = {a_reg, f_reg, 4'd0};
                            else
                                res.write_data = s16;
                        end
                    end
                    3'd6:
                    begin
                        al     = alu_op(y, a_reg, lo, f_reg);
                        a_next = al[11:4];
                        f_next = al[3:0];
                    end
                    default:
                    begin
                        sp_next          = sp_reg - 16'd2;
                        res.write_enable = 1'b1;
                        res.write_word   = 1'b1;
                        res.write_addr   = sp_reg - 16'd2;
                        res.write_data   = seq;
                        nxt              = {10'd0, y, 3'd0};
                    end
                endcase
            end
        endcase

        if (w8_en)
        begin
            case (w8_idx)
                3'd0: bc_next[15:8] = w8_val;
                3'd1: bc_next[7:0]  = w8_val;
                3'd2: de_next[15:8] = w8_val;
                3'd3: de_next[7:0]  = w8_val;
                3'd4: hl_next[15:8] = w8_val;
                3'd5: hl_next[7:0]  = w8_val;
                REG_MEM:
                begin
                    res.write_enable = 1'b1;
                    res.write_word   = 1'b0;
                    res.write_addr   = hl_reg;
                    res.write_data   = {8'd0, w8_val};
                end
                default: a_next = w8_val;
            endcase
        end

        pc_next        = nxt;
        res.next_pc    = nxt;
        res.acc_out    = a_next;
        res.flags_out  = f_next;
        res.irq_enable = ime_next;
        res.halted     = halt_next;
        res.stopped    = stop_next;
        res.illegal    = item.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_RESET;
            sp_reg   <= SP_RESET;
            bc_reg   <= BC_RESET;
            de_reg   <= DE_RESET;
            hl_reg   <= HL_RESET;
            a_reg    <= A_RESET;
            f_reg    <= F_RESET;
            ime_reg  <= 1'b0;
            halt_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (fire)
        begin
            pc_reg   <= pc_next;
            sp_reg   <= sp_next;
            bc_reg   <= bc_next;
            de_reg   <= de_next;
            hl_reg   <= hl_next;
            a_reg    <= a_next;
            f_reg    <= f_next;
            ime_reg  <= ime_next;
            halt_reg <= halt_next;
            stop_reg <= stop_next;
        end
    end
endmodule

### rtl/sm83_instruction_execute.sv
// SM83 instruction executor top level: front queue, execute stage, result queue.
// An item waits in the front queue; its result is registered in the result queue.
// Throughput: one instruction per cycle; stalls while the result queue is full.
// Reset (rst_n low, asynchronous) empties both queues and loads the register file,
// flags and status bits with their power-up values.
module sm83_instruction_execute #(
    parameter int IN_DEPTH  = sie_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = sie_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  opcode,
    input  logic [7:0]  imm_low,
    input  logic [7:0]  imm_high,
    input  logic [15:0] read_data,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] read_addr,
    output logic        write_enable,
    output logic [15:0] write_addr,
    output logic [15:0] write_data,
    output logic        write_word,
    output logic [15:0] next_pc,
    output logic [7:0]  acc_out,
    output logic [3:0]  flags_out,
    output logic        irq_enable,
    output logic        halted,
    output logic        stopped,
    output logic        illegal
);
    import sie_pkg::*;

    sie_item_t   item;
    sie_result_t res, res_q;
    logic        avail, out_full, fire;

    assign fire = avail && !out_full;

    sie_front #(.DEPTH(IN_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .imm_low   (imm_low),
        .imm_high  (imm_high),
        .read_data (read_data),
        .take      (fire),
        .avail     (avail),
        .item      (item)
    );

    sie_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res)
    );

    sie_fifo #(.W($bits(sie_result_t)), .DEPTH(OUT_DEPTH)) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .din   (res),
        .full  (out_full),
        .pop   (pop),
        .dout  (res_q),
        .empty (empty)
    );

    assign read_addr    = res_q.read_addr;
    assign write_enable = res_q.write_enable;
    assign write_addr   = res_q.write_addr;
    assign write_data   = res_q.write_data;
    assign write_word   = res_q.write_word;
    assign next_pc      = res_q.next_pc;
    assign acc_out      = res_q.acc_out;
    assign flags_out    = res_q.flags_out;
    assign irq_enable   = res_q.irq_enable;
    assign halted       = res_q.halted;
    assign stopped      = res_q.stopped;
    assign illegal      = res_q.illegal;
endmodule

### rtl/sie_checker.sv
// Port-level checks for sm83_instruction_execute, bound to the top level.
// Depends on sm83_instruction_execute.
module sie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        write_enable,
    input logic        illegal,
    input logic [15:0] next_pc
);
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting item lost");

    a_pc_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(next_pc))
        else $error("stalled item changed");

    a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && illegal) |-> !write_enable)
        else $error("unused opcode wrote memory");
endmodule

bind sm83_instruction_execute sie_checker u_sie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .write_enable (write_enable),
    .illegal      (illegal),
    .next_pc      (next_pc)
);

### verif/tb_top.sv
// Self-checking testbench for sm83_instruction_execute: a queue-fed driver, a
// monitor that checks each result item against an in-bench instruction model.
// Depends on rtl/sie_pkg.sv and rtl/sm83_instruction_execute.sv.
module tb_top;
    import sie_pkg::*;

    localparam logic [3:0] FZ = 4'b1000;
    localparam logic [3:0] FN = 4'b0100;
    localparam logic [3:0] FH = 4'b0010;
    localparam logic [3:0] FC = 4'b0001;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  imm_low;
        logic [7:0]  imm_high;
        logic [15:0] read_data;
    } instr_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [15:0] read_data;
    logic empty;
    logic pop;
    logic [15:0] read_addr;
    logic write_enable;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic write_word;
    logic [15:0] next_pc;
    logic [7:0] acc_out;
    logic [3:0] flags_out;
    logic irq_enable;
    logic halted;
    logic stopped;
    logic illegal;

    sm83_instruction_execute DUT (.*);

    instr_t      pending_instrs[$];
    sie_result_t expected_results[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_sender;
    int          quiet_cycles;

    // model state
    logic [15:0] m_pc, m_sp, m_bc, m_de, m_hl;
    logic [7:0]  m_a;
    logic [3:0]  m_f;
    logic        m_ime, m_halt, m_stop;
    logic [15:0] m_rd_addr, m_wr_addr, m_wr_data, m_mem;
    logic        m_wr_en, m_wr_word;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void model_reset();
        m_pc = 16'h0100; m_sp = 16'hFFFE; m_bc = 16'h0013; m_de = 16'h00D8;
        m_hl = 16'h014D; m_a = 8'h01; m_f = FZ | FH | FC;
        m_ime = 1'b0; m_halt = 1'b0; m_stop = 1'b0;
    endfunction

    function automatic void set_flags(bit z, bit n, bit h, bit c);
        m_f = {z, n, h, c};
    endfunction

    function automatic void mem_write(logic [15:0] a, logic [15:0] v, bit word);
        m_wr_en = 1'b1; m_wr_word = word; m_wr_addr = a;
        m_wr_data = word ? v : {8'h00, v[7:0]};
    endfunction

    function automatic logic [7:0] mem_read(logic [15:0] a);
        m_rd_addr = a;
        return m_mem[7:0];
    endfunction

    function automatic logic [15:0] stack_pop();
        m_rd_addr = m_sp;
        m_sp = m_sp + 16'd2;
        return m_mem;
    endfunction

    function automatic void stack_push(logic [15:0] v);
        m_sp = m_sp - 16'd2;
        mem_write(m_sp, v, 1'b1);
    endfunction

    function automatic logic [7:0] get_reg(logic [2:0] i);
        case (i)
            3'd0: return m_bc[15:8];
            3'd1: return m_bc[7:0];
            3'd2: return m_de[15:8];
            3'd3: return m_de[7:0];
            3'd4: return m_hl[15:8];
            3'd5: return m_hl[7:0];
            REG_MEM: return mem_read(m_hl);
            default: return m_a;
        endcase
    endfunction

    function automatic void set_reg(logic [2:0] i, logic [7:0] v);
        case (i)
            3'd0: m_bc[15:8] = v;
            3'd1: m_bc[7:0] = v;
            3'd2: m_de[15:8] = v;
            3'd3: m_de[7:0] = v;
            3'd4: m_hl[15:8] = v;
            3'd5: m_hl[7:0] = v;
            REG_MEM: mem_write(m_hl, {8'h00, v}, 1'b0);
            default: m_a = v;
        endcase
    endfunction

    function automatic logic [15:0] get_pair(logic [1:0] p);
        case (p)
            2'd0: return m_bc;
            2'd1: return m_de;
            2'd2: return m_hl;
            default: return m_sp;
        endcase
    endfunction

    function automatic void set_pair(logic [1:0] p, logic [15:0] v);
        case (p)
            2'd0: m_bc = v;
            2'd1: m_de = v;
            2'd2: m_hl = v;
            default: m_sp = v;
        endcase
    endfunction

    function automatic logic [7:0] rotate(logic [2:0] kind, logic [7:0] v, output bit co);
        bit ci;
        ci = m_f[0];
        case (kind)
            SH_RLC:  begin co = v[7]; return {v[6:0], v[7]}; end
            SH_RRC:  begin co = v[0]; return {v[0], v[7:1]}; end
            SH_RL:   begin co = v[7]; return {v[6:0], ci}; end
            SH_RR:   begin co = v[0]; return {ci, v[7:1]}; end
            SH_SLA:  begin co = v[7]; return {v[6:0], 1'b0}; end
            SH_SRA:  begin co = v[0]; return {v[7], v[7:1]}; end
            SH_SWAP: begin co = 1'b0; return {v[3:0], v[7:4]}; end
            default: begin co = v[0]; return {1'b0, v[7:1]}; end
        endcase
    endfunction

    function automatic void alu_op(logic [2:0] op, logic [7:0] v);
        logic [8:0] r;
        bit ci;
        ci = m_f[0];
        case (op)
            ALU_ADD, ALU_ADC:
            begin
                if (op == ALU_ADD) ci = 1'b0;
                r = m_a + v + ci;
                set_flags(r[7:0] == 0, 0, ({1'b0, m_a[3:0]} + v[3:0] + ci) > 5'd15, r[8]);
                m_a = r[7:0];
            end
            ALU_SUB, ALU_SBC, ALU_CP:
            begin
                if (op != ALU_SBC) ci = 1'b0;
                r = {1'b0, m_a} - v - ci;
                set_flags(r[7:0] == 0, 1, {1'b0, m_a[3:0]} < ({1'b0, v[3:0]} + ci),
                          {1'b0, m_a} < ({1'b0, v} + ci));
                if (op != ALU_CP) m_a = r[7:0];
            end
            ALU_AND: begin m_a = m_a & v; set_flags(m_a == 0, 0, 1, 0); end
            ALU_XOR: begin m_a = m_a ^ v; set_flags(m_a == 0, 0, 0, 0); end
            default: begin m_a = m_a | v; set_flags(m_a == 0, 0, 0, 0); end
        endcase
    endfunction

    function automatic bit cond_true(logic [1:0] cc);
        case (cc)
            2'd0: return !m_f[3];
            2'd1: return m_f[3];
            2'd2: return !m_f[0];
            default: return m_f[0];
        endcase
    endfunction

    function automatic logic [15:0] sp_plus(logic [7:0] e);
        set_flags(0, 0, ({1'b0, m_sp[3:0]} + e[3:0]) > 5'd15, ({1'b0, m_sp[7:0]} + e) > 9'd255);
        return m_sp + {{8{e[7]}}, e};
    endfunction

    function automatic logic [1:0] instr_len(logic [1:0] x, logic [2:0] y, logic [2:0] z);
        if (x == 0)
        begin
            if (z == 0) return (y == 0) ? 2'd1 : ((y == 1) ? 2'd3 : 2'd2);
            if (z == 1 && !y[0]) return 2'd3;
            if (z == 6) return 2'd2;
            return 2'd1;
        end
        if (x != 3) return 2'd1;
        case (z)
            3'd0: return (y >= 4) ? 2'd2 : 2'd1;
            3'd2: return (y < 4 || y == 5 || y == 7) ? 2'd3 : 2'd1;
            3'd3: return (y == 0) ? 2'd3 : ((y == 1) ? 2'd2 : 2'd1);
            3'd4: return (y < 4) ? 2'd3 : 2'd1;
            3'd5: return (y == 1) ? 2'd3 : 2'd1;
            3'd6: return 2'd2;
            default: return 2'd1;
        endcase
    endfunction

    function automatic void exec_cb(logic [7:0] op);
        logic [2:0] idx, b;
        logic [7:0] v, r;
        bit c;
        idx = op[2:0];
        b = op[5:3];
        v = get_reg(idx);
        case (op[7:6])
            2'd0:
            begin
                r = rotate(b, v, c);
                set_flags(r == 0, 0, 0, c);
                set_reg(idx, r);
            end
            2'd1: set_flags(!v[b], 0, 1, m_f[0]);
            2'd2: begin v[b] = 1'b0; set_reg(idx, v); end
            default: begin v[b] = 1'b1; set_reg(idx, v); end
        endcase
    endfunction

    function automatic sie_result_t execute_instr(instr_t it);
        sie_result_t res;
        logic [1:0] x, p;
        logic [2:0] y, z;
        bit q, bad, c;
        logic [7:0] lo, v;
        logic [15:0] nn, seq, nxt, h, s, w;
        logic [16:0] sum;
        logic [8:0] da;
        logic [3:0] f;
        lo = it.imm_low;
        nn = {it.imm_high, it.imm_low};
        x = it.opcode[7:6]; y = it.opcode[5:3]; z = it.opcode[2:0];
        p = y[2:1]; q = y[0];
        bad = 1'b0;
        m_mem = it.read_data;
        m_rd_addr = 0; m_wr_en = 0; m_wr_word = 0; m_wr_addr = 0; m_wr_data = 0;
        seq = m_pc + instr_len(x, y, z);
        nxt = seq;
        if (x == 0)
        begin
            case (z)
                3'd0:
                    if (y == 1) mem_write(nn, m_sp, 1'b1);
                    else if (y == 2) begin if (lo == 0) m_stop = 1'b1; end
                    else if (y == 3 || (y >= 4 && cond_true(y[1:0])))
                        nxt = seq + {{8{lo[7]}}, lo};
                3'd1:
                    if (!q) set_pair(p, nn);
                    else
                    begin
                        h = m_hl; s = get_pair(p); sum = h + s;
                        set_flags(m_f[3], 0, ({1'b0, h[11:0]} + s[11:0]) > 13'hFFF, sum[16]);
                        m_hl = sum[15:0];
                    end
                3'd2:
                begin
                    w = (p == 0) ? m_bc : ((p == 1) ? m_de : m_hl);
                    if (!q) mem_write(w, {8'h00, m_a}, 1'b0);
                    else m_a = mem_read(w);
                    if (p == 2) m_hl = m_hl + 16'd1;
                    if (p == 3) m_hl = m_hl - 16'd1;
                end
                3'd3: set_pair(p, q ? get_pair(p) - 16'd1 : get_pair(p) + 16'd1);
                3'd4:
                begin
                    v = get_reg(y);
                    set_flags(v == 8'hFF, 0, v[3:0] == 4'hF, m_f[0]);
                    set_reg(y, v + 8'd1);
                end
                3'd5:
                begin
                    v = get_reg(y);
                    set_flags(v == 8'h01, 1, v[3:0] == 4'h0, m_f[0]);
                    set_reg(y, v - 8'd1);
                end
                3'd6: set_reg(y, lo);
                default:
                    if (y < 4)
                    begin
                        m_a = rotate(y, m_a, c);
                        set_flags(0, 0, 0, c);
                    end
                    else if (y == 4)
                    begin
                        da = {1'b0, m_a}; f = m_f; c = f[0];
                        if (!f[2])
                        begin
                            if (c || da > 9'h99) begin da = da + 9'h60; c = 1'b1; end
                            if (f[1] || da[3:0] > 4'd9) da = da + 9'd6;
                        end
                        else
                        begin
                            if (c) da = da - 9'h60;
                            if (f[1]) da = da - 9'd6;
                        end
                        m_a = da[7:0];
                        set_flags(m_a == 0, f[2], 0, c);
                    end
                    else if (y == 5) begin m_a = ~m_a; m_f = m_f | FN | FH; end
                    else if (y == 6) set_flags(m_f[3], 0, 0, 1);
                    else set_flags(m_f[3], 0, 0, !m_f[0]);
            endcase
        end
        else if (x == 1)
        begin
            if (y == 6 && z == 6) m_halt = 1'b1;
            else set_reg(y, get_reg(z));
        end
        else if (x == 2) alu_op(y, get_reg(z));
        else
        begin
            case (z)
                3'd0:
                    if (y < 4) begin if (cond_true(y[1:0])) nxt = stack_pop(); end
                    else if (y == 4) mem_write({8'hFF, lo}, {8'h00, m_a}, 1'b0);
                    else if (y == 5) m_sp = sp_plus(lo);
                    else if (y == 6) m_a = mem_read({8'hFF, lo});
                    else m_hl = sp_plus(lo);
                3'd1:
                    if (!q)
                    begin
                        w = stack_pop();
                        if (p == 3) begin m_a = w[15:8]; m_f = w[7:4]; end
                        else set_pair(p, w);
                    end
                    else if (p == 0) nxt = stack_pop();
                    else if (p == 1) begin nxt = stack_pop(); m_ime = 1'b1; end
                    else if (p == 2) nxt = m_hl;
                    else m_sp = m_hl;
                3'd2:
                    if (y < 4) begin if (cond_true(y[1:0])) nxt = nn; end
                    else if (y == 4) mem_write({8'hFF, m_bc[7:0]}, {8'h00, m_a}, 1'b0);
                    else if (y == 5) mem_write(nn, {8'h00, m_a}, 1'b0);
                    else if (y == 6) m_a = mem_read({8'hFF, m_bc[7:0]});
                    else m_a = mem_read(nn);
                3'd3:
                    if (y == 0) nxt = nn;
                    else if (y == 1) exec_cb(lo);
                    else if (y == 6) m_ime = 1'b0;
                    else if (y == 7) m_ime = 1'b1;
                    else bad = 1'b1;
                3'd4:
                    if (y < 4) begin if (cond_true(y[1:0])) begin stack_push(seq); nxt = nn; end end
                    else bad = 1'b1;
                3'd5:
                    if (!q) stack_push(p == 3 ? {m_a, m_f, 4'h0} : get_pair(p));
                    else if (p == 0) begin stack_push(seq); nxt = nn; end
                    else bad = 1'b1;
                3'd6: alu_op(y, lo);
                default: begin stack_push(seq); nxt = {10'd0, y, 3'd0}; end
            endcase
        end
        m_pc = nxt;
        res.read_addr = m_rd_addr;
        res.write_enable = m_wr_en;
        res.write_addr = m_wr_addr;
        res.write_data = m_wr_data;
        res.write_word = m_wr_word;
        res.next_pc = m_pc;
        res.acc_out = m_a;
        res.flags_out = m_f;
        res.irq_enable = m_ime;
        res.halted = m_halt;
        res.stopped = m_stop;
        res.illegal = bad;
        return res;
    endfunction

    function automatic instr_t make_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                                          logic [15:0] rd);
        instr_t it;
        it.opcode = op; it.imm_low = lo; it.imm_high = hi; it.read_data = rd;
        return it;
    endfunction

    function automatic instr_t rand_instr(logic [7:0] op);
        return make_instr(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            opcode <= 8'h00;
            imm_low <= 8'h00;
            imm_high <= 8'h00;
            read_data <= 16'h0000;
        end
        else
        begin
            if (!push || !full)
            begin
                if (pending_instrs.size() > 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    instr_t it;
                    it = pending_instrs.pop_front();
                    expected_results.push_back(execute_instr(it));
                    push <= 1'b1;
                    opcode <= it.opcode;
                    imm_low <= it.imm_low;
                    imm_high <= it.imm_high;
                    read_data <= it.read_data;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expectation pending");
                    errors++;
                end
                else
                begin
                    sie_result_t e;
                    e = expected_results.pop_front();
                    if (read_addr !== e.read_addr)
                    begin $error("read_addr exp %h got %h", e.read_addr, read_addr); errors++; end
                    if (write_enable !== e.write_enable)
                    begin $error("write_enable exp %h got %h", e.write_enable, write_enable); errors++; end
                    if (write_addr !== e.write_addr)
                    begin $error("write_addr exp %h got %h", e.write_addr, write_addr); errors++; end
                    if (write_data !== e.write_data)
                    begin $error("write_data exp %h got %h", e.write_data, write_data); errors++; end
                    if (write_word !== e.write_word)
                    begin $error("write_word exp %h got %h", e.write_word, write_word); errors++; end
                    if (next_pc !== e.next_pc)
                    begin $error("next_pc exp %h got %h", e.next_pc, next_pc); errors++; end
                    if (acc_out !== e.acc_out)
                    begin $error("acc_out exp %h got %h", e.acc_out, acc_out); errors++; end
                    if (flags_out !== e.flags_out)
                    begin $error("flags_out exp %h got %h", e.flags_out, flags_out); errors++; end
                    if (irq_enable !== e.irq_enable)
                    begin $error("irq_enable exp %h got %h", e.irq_enable, irq_enable); errors++; end
                    if (halted !== e.halted)
                    begin $error("halted exp %h got %h", e.halted, halted); errors++; end
                    if (stopped !== e.stopped)
                    begin $error("stopped exp %h got %h", e.stopped, stopped); errors++; end
                    if (illegal !== e.illegal)
                    begin $error("illegal exp %h got %h", e.illegal, illegal); errors++; end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("sm83_instruction_execute verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_instrs.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            logic [7:0] op;
            op = 8'($urandom_range(0, 255));
            // bias toward the CB prefix
            if ($urandom_range(0, 9) == 0) op = 8'hCB;
            pending_instrs.push_back(rand_instr(op));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        hold_sender = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 61;
        model_reset();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = 8'h00;
        imm_low = 8'h00;
        imm_high = 8'h00;
        read_data = 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, prefix, stack, STOP, HALT, unused, DAA, RETI
        pending_instrs.push_back(make_instr(8'h00, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h10, 8'h01, 8'hFF, 16'hFFFF));
        pending_instrs.push_back(make_instr(8'h10, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h3E, 8'hFF, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hC6, 8'h01, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h27, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hD6, 8'h01, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h27, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h07, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hCB, 8'h2F, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hCB, 8'h2E, 8'h00, 16'h0080));
        pending_instrs.push_back(make_instr(8'hCB, 8'hFF, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hF5, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hF1, 8'h00, 8'h00, 16'hFFFF));
        pending_instrs.push_back(make_instr(8'hD9, 8'h00, 8'h00, 16'h1234));
        pending_instrs.push_back(make_instr(8'hF3, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hFB, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hD3, 8'hFF, 8'hFF, 16'hFFFF));
        pending_instrs.push_back(make_instr(8'hFD, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hE8, 8'h80, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hF8, 8'h7F, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h39, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'h76, 8'h00, 8'h00, 16'h0000));
        pending_instrs.push_back(make_instr(8'hCD, 8'hFF, 8'hFF, 16'h0000));
        pending_instrs.push_back(make_instr(8'hFF, 8'h00, 8'h00, 16'h0000));
        queue_random(200);
        wait_drained();

        // sender holds until everything has drained
        hold_sender = 1'b1;
        queue_random(30);
        while (expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
        queue_random(200);
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 25;
        queue_random(120);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(130);
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("sm83_instruction_execute verification clean");
        else
            $display("sm83_instruction_execute verification failed");
        $finish;
    end
endmodule
